// ===== rtl/stepper_position_controller_defines.svh =====
// Shared assertion macros for the stepper position controller checks.
`ifndef STEPPER_POSITION_CONTROLLER_DEFINES_SVH
`define STEPPER_POSITION_CONTROLLER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define STPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stpc check failed");

// Next-cycle implication, held off while reset is asserted.
`define STPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stpc check failed");

`endif

// ===== rtl/stpc_pkg.sv =====
package stpc_pkg;

  localparam int VALUE_W     = 32;
  localparam int OUT_POS_W   = 32;
  localparam int DWELL_W     = 16;
  localparam int DWELL_CNT_W = 17;
  localparam int COIL_W      = 4;
  localparam int OUT_DATA_W  = 40;

  typedef enum logic [1:0] {
    ACT_SET_TARGET = 2'd0,
    ACT_TICK       = 2'd1,
    ACT_SET_REF    = 2'd2,
    ACT_ADJUST     = 2'd3
  } action_t;

  localparam logic [1:0] MODE_RELEASE = 2'd0;
  localparam logic [1:0] MODE_HOLD    = 2'd1;
  localparam logic [1:0] MODE_REVERSE = 2'd2;

  localparam logic [1:0] CFG_STOP_MODE = 2'd0;
  localparam logic [1:0] CFG_DWELL     = 2'd1;
  localparam logic [1:0] CFG_HOME_HIGH = 2'd2;

  localparam logic [COIL_W-1:0] COIL_OFF  = 4'b0000;
  localparam logic [COIL_W-1:0] COIL_HOLD = 4'b0001;

  typedef struct packed {
    logic [1:0]         stop_mode;
    logic [DWELL_W-1:0] dwell_steps;
    logic [VALUE_W-1:0] home_high;
  } cfg_t;

  // Packed so that coils land in the low bits of the result bus.
  typedef struct packed {
    logic                 moving_up;
    logic                 reached;
    logic                 running;
    logic [OUT_POS_W-1:0] position;
    logic [COIL_W-1:0]    coils;
  } result_t;

  // One coil of the drive sequence. Forward: IN1 IN3 IN2 IN4,
  // reverse: IN1 IN4 IN2 IN3.
  function automatic logic [COIL_W-1:0] seq_bit(input logic neg, input logic [1:0] slot);
    logic [COIL_W-1:0] bits;
    bits = COIL_OFF;
    unique case (slot)
      2'd0: bits = 4'b0001;
      2'd1: bits = neg ? 4'b1000 : 4'b0100;
      2'd2: bits = 4'b0010;
      2'd3: bits = neg ? 4'b0100 : 4'b1000;
      default: bits = COIL_OFF;
    endcase
    return bits;
  endfunction

endpackage

// ===== rtl/stpc_core.sv =====
module stpc_core #(
  parameter int POSITION_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  stpc_pkg::action_t               action,
  input  logic [stpc_pkg::VALUE_W-1:0]    value,
  input  stpc_pkg::cfg_t                  cfg,
  output stpc_pkg::result_t               res_nxt
);

  logic [POSITION_BITS-1:0] pos_r, pos_nxt, tgt_r, tgt_nxt;
  logic [1:0]               ph_r, ph_nxt;
  logic                     up_r, up_nxt, dn_r, dn_nxt;
  logic                     run_r, run_nxt, reach_r, reach_nxt;
  logic [stpc_pkg::DWELL_CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [stpc_pkg::COIL_W-1:0]      coil_r, coil_nxt, halt_coil;
  logic [POSITION_BITS-1:0] val_p, home_p, pos_step;
  logic                     mode_rev;

  assign val_p     = POSITION_BITS'($signed(value));
  assign home_p    = POSITION_BITS'($signed(cfg.home_high));
  assign pos_step  = up_r ? pos_r + POSITION_BITS'(1) :
                     dn_r ? pos_r - POSITION_BITS'(1) : pos_r;
  assign cnt_inc   = cnt_r + stpc_pkg::DWELL_CNT_W'(1);
  assign halt_coil = (cfg.stop_mode == stpc_pkg::MODE_HOLD) ? stpc_pkg::COIL_HOLD
                                                           : stpc_pkg::COIL_OFF;
  assign mode_rev  = (cfg.stop_mode == stpc_pkg::MODE_REVERSE);

  always_comb begin
    pos_nxt   = pos_r;
    tgt_nxt   = tgt_r;
    ph_nxt    = ph_r;
    up_nxt    = up_r;
    dn_nxt    = dn_r;
    run_nxt   = run_r;
    reach_nxt = reach_r;
    cnt_nxt   = cnt_r;
    coil_nxt  = coil_r;
    unique case (action)
      stpc_pkg::ACT_SET_TARGET: begin
        tgt_nxt   = val_p;
        reach_nxt = 1'b0;
        if ($signed(val_p) > $signed(pos_r)) begin
          up_nxt  = 1'b1;
          dn_nxt  = 1'b0;
          run_nxt = 1'b1;
        end else if ($signed(val_p) < $signed(pos_r)) begin
          up_nxt  = 1'b0;
          dn_nxt  = 1'b1;
          run_nxt = 1'b1;
        end else begin
          run_nxt  = 1'b0;
          coil_nxt = halt_coil;
        end
      end
      stpc_pkg::ACT_TICK: begin
        if (run_r) begin
          coil_nxt = stpc_pkg::seq_bit(dn_r, ph_r) | stpc_pkg::seq_bit(dn_r, ph_r + 2'd1);
          ph_nxt   = ph_r + 2'd1;
          pos_nxt  = pos_step;
          if (pos_step == tgt_r) begin
            if (mode_rev) begin
              reach_nxt = 1'b1;
            end else begin
              run_nxt  = 1'b0;
              coil_nxt = halt_coil;
            end
          end
          // dwell count runs once the target was reached, then flips direction
          if (mode_rev && reach_nxt) begin
            cnt_nxt = cnt_inc;
            if (cnt_inc > {1'b0, cfg.dwell_steps}) begin
              if (dn_r) begin
                up_nxt = 1'b1;
                dn_nxt = 1'b0;
              end else if (up_r) begin
                up_nxt = 1'b0;
                dn_nxt = 1'b1;
              end
              cnt_nxt = '0;
            end
          end
        end
      end
      stpc_pkg::ACT_SET_REF: begin
        pos_nxt = (value != '0) ? home_p : '0;
      end
      stpc_pkg::ACT_ADJUST: begin
        pos_nxt = pos_r + val_p;
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      tgt_r   <= '0;
      ph_r    <= '0;
      up_r    <= 1'b0;
      dn_r    <= 1'b0;
      run_r   <= 1'b0;
      reach_r <= 1'b0;
      cnt_r   <= '0;
      coil_r  <= stpc_pkg::COIL_OFF;
    end else if (en) begin
      pos_r   <= pos_nxt;
      tgt_r   <= tgt_nxt;
      ph_r    <= ph_nxt;
      up_r    <= up_nxt;
      dn_r    <= dn_nxt;
      run_r   <= run_nxt;
      reach_r <= reach_nxt;
      cnt_r   <= cnt_nxt;
      coil_r  <= coil_nxt;
    end
  end

  always_comb begin
    res_nxt.coils     = coil_nxt;
    res_nxt.position  = stpc_pkg::OUT_POS_W'($signed(pos_nxt));
    res_nxt.running   = run_nxt;
    res_nxt.reached   = reach_nxt;
    res_nxt.moving_up = up_nxt;
  end

endmodule

// ===== rtl/stepper_position_controller.sv =====
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    tuser: action; tdata: value
// out_     out  out_tvalid/out_tready  tdata: coils, position, running, reached, moving_up
// cfg_     in   cfg_we                 cfg_addr: register index; cfg_wdata: data
//
// One request per clock sustained while out_tready stays high; a request's result passes
// the input register, then the single-pass update feeding the result register.
// rst_n is synchronous, active low: clears both pipeline registers, all motor state
// and loads the register defaults (stop_mode 0, dwell_steps 200, home_high_position 0).
// A stalled result holds the result register; the input register still takes one more
// request, then in_tready drops until out_tready frees the result register.
module stepper_position_controller #(
  parameter int POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] coils, [35:4] position, [36] running,
                                  // [37] reached, [38] moving_up, [39] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  // request register
  logic                              in_valid_r;
  stpc_pkg::action_t                 in_action_r;
  logic [stpc_pkg::VALUE_W-1:0]      in_value_r;
  logic                              advance;

  // result register
  logic                              out_valid_r;
  stpc_pkg::result_t                 res_r, res_nxt;

  stpc_pkg::cfg_t                    cfg_r;

  // a request moves into the core when the result slot is free or draining
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_action_r <= stpc_pkg::action_t'(in_tuser);
      in_value_r  <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_mode   <= stpc_pkg::MODE_RELEASE;
      cfg_r.dwell_steps <= stpc_pkg::DWELL_W'(200);
      cfg_r.home_high   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        stpc_pkg::CFG_STOP_MODE: cfg_r.stop_mode   <= cfg_wdata[1:0];
        stpc_pkg::CFG_DWELL:     cfg_r.dwell_steps <= cfg_wdata[stpc_pkg::DWELL_W-1:0];
        stpc_pkg::CFG_HOME_HIGH: cfg_r.home_high   <= cfg_wdata;
        default:                 cfg_r             <= cfg_r;  // unused index
      endcase
    end
  end

  stpc_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .action  (in_action_r),
    .value   (in_value_r),
    .cfg     (cfg_r),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r};

endmodule

// ===== rtl/stpc_checker.sv =====
`include "stepper_position_controller_defines.svh"

module stpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // a stalled result stays up and unchanged
  `STPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // with the result slot empty the block must take requests
  `STPC_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)

  // a stopped motor drives at most the holding coil
  `STPC_ASSERT_IMPL(a_stopped_coils, clk, rst_n, out_tvalid && !out_tdata[36], out_tdata[3:1] == 3'b000)

  // a request taken with the pipe empty shows its result once through the input and result registers
  `STPC_ASSERT_IMPL(a_latency, clk, rst_n, $past(in_tvalid && in_tready && !out_tvalid && out_tready, 2), out_tvalid)

endmodule

bind stepper_position_controller stpc_checker u_stpc_checker (.*);
